// ===== hw/rtl/bbpr_pkg.sv =====
// ============================================================================
// bbpr_pkg
// Shared types, constants and helpers for the packed board record encoder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bbpr_pkg;

    localparam int unsigned SQUARES      = 64;
    localparam int unsigned SQ_W         = 7;     // 0..63, 64 means "none"
    localparam int unsigned SLOTS        = 32;    // nibbles in one record
    localparam int unsigned SLOT_W       = 5;
    localparam int unsigned CODE_W       = 4;
    localparam int unsigned MAX_PIECES_D = 32;

    localparam logic [SQ_W-1:0] RANK_FLIP = 7'd56;
    localparam logic [1:0]      OUT_WIN   = 2'd2;

    localparam logic [2:0] PC_PAWN   = 3'd0;
    localparam logic [2:0] PC_KNIGHT = 3'd1;
    localparam logic [2:0] PC_BISHOP = 3'd2;
    localparam logic [2:0] PC_ROOK   = 3'd3;
    localparam logic [2:0] PC_QUEEN  = 3'd4;
    localparam logic [2:0] PC_KING   = 3'd5;

    typedef struct packed {
        logic [63:0]        white_pieces;
        logic [63:0]        black_pieces;
        logic [63:0]        pawn_board;
        logic [63:0]        knight_board;
        logic [63:0]        bishop_board;
        logic [63:0]        rook_board;
        logic [63:0]        queen_board;
        logic [63:0]        king_board;
        logic               black_to_move;
        logic signed [15:0] score_white_view;
        logic [1:0]         game_outcome;
    } t_in_item;

    typedef struct packed {
        logic [63:0]        occupancy;
        logic [63:0]        codes_low;
        logic [63:0]        codes_high;
        logic signed [15:0] score_mover_view;
        logic [1:0]         outcome_mover_view;
        logic [SQ_W-1:0]    own_king_square;
        logic [SQ_W-1:0]    other_king_square;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KING_OWN,
        ST_KING_OTHER,
        ST_WALK
    } t_state;

    // vertical mirror: byte swap
    function automatic logic [63:0] mirror_ranks(input logic [63:0] b);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[8*(7-i) +: 8] = b[8*i +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bbpr_lsb.sv =====
// ============================================================================
// bbpr_lsb
// Lowest set square of a 64-bit board: isolated bit and square index.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bbpr_lsb (
    input  wire logic [63:0]                  i_board,
    output logic      [63:0]                  o_onehot,
    output logic      [bbpr_pkg::SQ_W-1:0]    o_square
);

    logic [5:0] w_low;

    assign o_onehot = i_board & (~i_board + 64'd1);

    // OR of the positions of the single surviving bit
    always_comb begin
        w_low = '0;
        for (int j = 0; j < 64; j++) begin
            w_low = w_low | (o_onehot[j] ? 6'(j) : 6'd0);
        end
    end

    // empty board reports square 64
    assign o_square = {(i_board == 64'd0), w_low};

endmodule

`default_nettype wire

// ===== hw/rtl/bitboard_to_packed_board_record.sv =====
// ============================================================================
// bitboard_to_packed_board_record
// Encodes one chess position into a 28-byte record seen from the mover.
// ============================================================================
// The boards are mirrored, when black is to move, as the item is taken.
// ST_KING_OWN and ST_KING_OTHER locate the kings, ST_WALK codes the occupied
// squares in turn, up to MAX_PIECES of them, and then the output register is loaded.
// All searches run through a single lowest-set-bit unit that the sequencer
// points at the own king, the other king and then the remaining occupancy.
// The input is stalled from the edge that takes an item until its record is
// loaded, so no new item is taken while one is being encoded. A loaded record
// waits in the output register and the next item can be taken meanwhile. If an
// earlier record is still waiting, the walk holds in its last state until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none

module bitboard_to_packed_board_record #(
    parameter int unsigned MAX_PIECES = bbpr_pkg::MAX_PIECES_D
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire bbpr_pkg::t_in_item    i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output bbpr_pkg::t_out_item        o_out_data
);

    localparam int unsigned CNT_W = $clog2(MAX_PIECES + 1);

    bbpr_pkg::t_state r_state, n_state;

    logic [63:0] r_own, r_opp, r_pawn, r_knight, r_bishop, r_rook, r_queen, r_king;
    logic [63:0] r_occ, r_rest;
    logic [bbpr_pkg::SLOTS*bbpr_pkg::CODE_W-1:0] r_codes;
    logic [CNT_W-1:0]           r_idx;
    logic signed [15:0]         r_score;
    logic [1:0]                 r_outcome;
    logic [bbpr_pkg::SQ_W-1:0]  r_own_k, r_opp_k;
    logic                       r_out_valid;
    bbpr_pkg::t_out_item        r_out;

    logic                       w_accept, w_out_free, w_walk_done;
    logic                       w_ld_own_k, w_ld_opp_k, w_step, w_load_out;
    logic [63:0]                w_unit_in, w_onehot;
    logic [bbpr_pkg::SQ_W-1:0]  w_square;
    logic [2:0]                 w_piece;
    logic [bbpr_pkg::CODE_W-1:0] w_code;

    // prepared item
    logic               w_flip;
    logic [63:0]        w_white_m, w_black_m;
    logic signed [15:0] w_score;
    logic [1:0]         w_outc, w_outcome;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_walk_done = (r_rest == 64'd0) || (r_idx == CNT_W'(MAX_PIECES));

    // ------------------------------------------------------------------
    // shared search unit
    // ------------------------------------------------------------------
    always_comb begin
        case (r_state)
            bbpr_pkg::ST_KING_OWN:   w_unit_in = r_own & r_king;
            bbpr_pkg::ST_KING_OTHER: w_unit_in = r_opp & r_king;
            default:                 w_unit_in = r_rest;
        endcase
    end

    bbpr_lsb u_lsb (
        .i_board  (w_unit_in),
        .o_onehot (w_onehot),
        .o_square (w_square)
    );

    always_comb begin
        if ((w_onehot & r_pawn) != 64'd0)        w_piece = bbpr_pkg::PC_PAWN;
        else if ((w_onehot & r_knight) != 64'd0) w_piece = bbpr_pkg::PC_KNIGHT;
        else if ((w_onehot & r_bishop) != 64'd0) w_piece = bbpr_pkg::PC_BISHOP;
        else if ((w_onehot & r_rook) != 64'd0)   w_piece = bbpr_pkg::PC_ROOK;
        else if ((w_onehot & r_queen) != 64'd0)  w_piece = bbpr_pkg::PC_QUEEN;
        else if ((w_onehot & r_king) != 64'd0)   w_piece = bbpr_pkg::PC_KING;
        else                                     w_piece = bbpr_pkg::PC_PAWN;
    end

    assign w_code = {((w_onehot & r_opp) != 64'd0), w_piece};

    // ------------------------------------------------------------------
    // input preparation
    // ------------------------------------------------------------------
    assign w_flip    = i_in_data.black_to_move;
    assign w_white_m = w_flip ? bbpr_pkg::mirror_ranks(i_in_data.white_pieces)
                              : i_in_data.white_pieces;
    assign w_black_m = w_flip ? bbpr_pkg::mirror_ranks(i_in_data.black_pieces)
                              : i_in_data.black_pieces;
    assign w_outc    = (i_in_data.game_outcome > bbpr_pkg::OUT_WIN) ?
                       bbpr_pkg::OUT_WIN : i_in_data.game_outcome;

    always_comb begin
        if (!w_flip) begin
            w_score   = i_in_data.score_white_view;
            w_outcome = w_outc;
        end else begin
            // negating the most negative value saturates
            if (i_in_data.score_white_view == 16'sh8000) begin
                w_score = 16'sh7FFF;
            end else begin
                w_score = -i_in_data.score_white_view;
            end
            w_outcome = bbpr_pkg::OUT_WIN - w_outc;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbpr_pkg::ST_IDLE: begin
                if (w_accept) n_state = bbpr_pkg::ST_KING_OWN;
            end
            bbpr_pkg::ST_KING_OWN:   n_state = bbpr_pkg::ST_KING_OTHER;
            bbpr_pkg::ST_KING_OTHER: n_state = bbpr_pkg::ST_WALK;
            bbpr_pkg::ST_WALK: begin
                if (w_walk_done && w_out_free) n_state = bbpr_pkg::ST_IDLE;
            end
            default: n_state = bbpr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_ld_own_k = 1'b0;
        w_ld_opp_k = 1'b0;
        w_step     = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            bbpr_pkg::ST_IDLE:       o_in_stall = 1'b0;
            bbpr_pkg::ST_KING_OWN:   w_ld_own_k = 1'b1;
            bbpr_pkg::ST_KING_OTHER: w_ld_opp_k = 1'b1;
            bbpr_pkg::ST_WALK: begin
                w_step     = !w_walk_done;
                w_load_out = w_walk_done && w_out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbpr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_own     <= w_flip ? w_black_m : w_white_m;
            r_opp     <= w_flip ? w_white_m : w_black_m;
            r_pawn    <= w_flip ? bbpr_pkg::mirror_ranks(i_in_data.pawn_board)
                                : i_in_data.pawn_board;
            r_knight  <= w_flip ? bbpr_pkg::mirror_ranks(i_in_data.knight_board)
                                : i_in_data.knight_board;
            r_bishop  <= w_flip ? bbpr_pkg::mirror_ranks(i_in_data.bishop_board)
                                : i_in_data.bishop_board;
            r_rook    <= w_flip ? bbpr_pkg::mirror_ranks(i_in_data.rook_board)
                                : i_in_data.rook_board;
            r_queen   <= w_flip ? bbpr_pkg::mirror_ranks(i_in_data.queen_board)
                                : i_in_data.queen_board;
            r_king    <= w_flip ? bbpr_pkg::mirror_ranks(i_in_data.king_board)
                                : i_in_data.king_board;
            r_occ     <= w_white_m | w_black_m;
            r_rest    <= w_white_m | w_black_m;
            r_codes   <= '0;
            r_idx     <= '0;
            r_score   <= w_score;
            r_outcome <= w_outcome;
        end
        if (w_ld_own_k) r_own_k <= w_square;
        if (w_ld_opp_k) r_opp_k <= w_square ^ bbpr_pkg::RANK_FLIP;
        if (w_step) begin
            r_codes[bbpr_pkg::CODE_W*bbpr_pkg::SLOT_W'(r_idx) +: bbpr_pkg::CODE_W] <= w_code;
            r_rest <= r_rest & ~w_onehot;
            r_idx  <= r_idx + CNT_W'(1);
        end
        if (w_load_out) begin
            r_out.occupancy          <= r_occ;
            r_out.codes_low          <= r_codes[63:0];
            r_out.codes_high         <= r_codes[127:64];
            r_out.score_mover_view   <= r_score;
            r_out.outcome_mover_view <= r_outcome;
            r_out.own_king_square    <= r_own_k;
            r_out.other_king_square  <= r_opp_k;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bbpr_pkg::ST_IDLE) |-> (r_idx <= CNT_W'(MAX_PIECES)))
        else $error("piece count past limit");

    a_rest_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bbpr_pkg::ST_IDLE) |-> ((r_rest & ~r_occ) == 64'd0))
        else $error("remaining squares not within occupancy");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bbpr_pkg::ST_IDLE) |->
        (32'($countones(r_occ)) - 32'($countones(r_rest)) == 32'(r_idx)))
        else $error("coded piece count disagrees with cleared squares");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == bbpr_pkg::ST_KING_OWN))
        else $error("accepted item did not start king search");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> r_out_valid)
        else $error("record loaded but not presented");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Drives chess positions into the encoder and checks every record against a
// local predictor of the mirror, piece walk, score/outcome flip and king
// search. Sender gaps and receiver stalls vary by phase.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int PIECE_LIMIT = bbpr_pkg::MAX_PIECES_D;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 64;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    bbpr_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    bbpr_pkg::t_out_item o_out_data;

    bbpr_pkg::t_out_item pending_records[$];
    int        mismatch_count;
    int        records_checked;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    bitboard_to_packed_board_record dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] swap_ranks(input logic [63:0] b);
        logic [63:0] r;
        for (int sq = 0; sq < bbpr_pkg::SQUARES; sq++) begin
            r[sq ^ 56] = b[sq];
        end
        return r;
    endfunction

    function automatic logic [bbpr_pkg::SQ_W-1:0] first_square(input logic [63:0] b);
        logic [bbpr_pkg::SQ_W-1:0] sq;
        sq = bbpr_pkg::SQ_W'(bbpr_pkg::SQUARES);
        for (int i = bbpr_pkg::SQUARES - 1; i >= 0; i--) begin
            if (b[i]) sq = bbpr_pkg::SQ_W'(i);
        end
        return sq;
    endfunction

    function automatic bbpr_pkg::t_out_item predict_record(input bbpr_pkg::t_in_item p);
        logic [63:0]  own, other, pawn, knight, bishop, rook, queen, king, tmp;
        logic [63:0]  occ;
        logic [127:0] nibbles;
        logic [2:0]   pc;
        int           sc;
        logic [1:0]   outc;
        int           idx;
        bbpr_pkg::t_out_item r;
        own    = p.white_pieces;
        other  = p.black_pieces;
        pawn   = p.pawn_board;
        knight = p.knight_board;
        bishop = p.bishop_board;
        rook   = p.rook_board;
        queen  = p.queen_board;
        king   = p.king_board;
        sc     = p.score_white_view;
        outc   = (p.game_outcome > bbpr_pkg::OUT_WIN) ? bbpr_pkg::OUT_WIN : p.game_outcome;
        if (p.black_to_move) begin
            tmp    = swap_ranks(own);
            own    = swap_ranks(other);
            other  = tmp;
            pawn   = swap_ranks(pawn);
            knight = swap_ranks(knight);
            bishop = swap_ranks(bishop);
            rook   = swap_ranks(rook);
            queen  = swap_ranks(queen);
            king   = swap_ranks(king);
            sc     = -sc;
            if (sc > 32767) sc = 32767;
            outc   = bbpr_pkg::OUT_WIN - outc;
        end
        occ     = own | other;
        nibbles = '0;
        idx     = 0;
        for (int sq = 0; sq < bbpr_pkg::SQUARES; sq++) begin
            if (occ[sq] && idx < PIECE_LIMIT) begin
                if (pawn[sq])        pc = bbpr_pkg::PC_PAWN;
                else if (knight[sq]) pc = bbpr_pkg::PC_KNIGHT;
                else if (bishop[sq]) pc = bbpr_pkg::PC_BISHOP;
                else if (rook[sq])   pc = bbpr_pkg::PC_ROOK;
                else if (queen[sq])  pc = bbpr_pkg::PC_QUEEN;
                else if (king[sq])   pc = bbpr_pkg::PC_KING;
                else                 pc = bbpr_pkg::PC_PAWN;  // square in no piece board
                nibbles[4*idx +: 4] = {other[sq], pc};
                idx++;
            end
        end
        r.occupancy          = occ;
        r.codes_low          = nibbles[63:0];
        r.codes_high         = nibbles[127:64];
        r.score_mover_view   = sc[15:0];
        r.outcome_mover_view = outc;
        r.own_king_square    = first_square(own & king);
        r.other_king_square  = first_square(other & king) ^ bbpr_pkg::RANK_FLIP;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR record %0d: %s", records_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic check_record(input bbpr_pkg::t_out_item got);
        bbpr_pkg::t_out_item want;
        if (pending_records.size() == 0) begin
            report_mismatch("record with no item pending");
        end else begin
            want = pending_records.pop_front();
            check_field("occupancy", got.occupancy, want.occupancy);
            check_field("codes_low", got.codes_low, want.codes_low);
            check_field("codes_high", got.codes_high, want.codes_high);
            check_field("score", 64'(got.score_mover_view), 64'(want.score_mover_view));
            check_field("outcome", 64'(got.outcome_mover_view),
                        64'(want.outcome_mover_view));
            check_field("own_king", 64'(got.own_king_square), 64'(want.own_king_square));
            check_field("other_king", 64'(got.other_king_square),
                        64'(want.other_king_square));
        end
        records_checked++;
    endtask

    // receiver: samples pre-edge values, then picks the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_record(o_out_data);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Called just after a rising edge; returns at the edge that took the item.
    task automatic send_position(input bbpr_pkg::t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        pending_records = {pending_records, predict_record(item)};
    endtask

    task automatic wait_all_returned();
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bbpr_pkg::t_in_item position(
        input logic [63:0] w, b, pa, kn, bi, ro, qu, ki,
        input logic btm, input logic [15:0] score, input logic [1:0] outc);
        bbpr_pkg::t_in_item p;
        p.white_pieces     = w;
        p.black_pieces     = b;
        p.pawn_board       = pa;
        p.knight_board     = kn;
        p.bishop_board     = bi;
        p.rook_board       = ro;
        p.queen_board      = qu;
        p.king_board       = ki;
        p.black_to_move    = btm;
        p.score_white_view = score;
        p.game_outcome     = outc;
        return p;
    endfunction

    function automatic logic [15:0] random_score();
        case ($urandom_range(9))
            0:       return 16'sd30000;
            1:       return -16'sd30000;
            2:       return 16'h8000;
            default: return 16'($urandom_range(60000)) - 16'd30000;
        endcase
    endfunction

    // legal-looking position: distinct squares, usually one king per side
    function automatic bbpr_pkg::t_in_item legal_position(input int n);
        bbpr_pkg::t_in_item p;
        logic [63:0] occ;
        logic [63:0] sq_bit;
        logic [2:0]  kind;
        bit          is_black;
        bit          with_kings;
        p          = '0;
        occ        = '0;
        with_kings = ($urandom_range(19) != 0);
        for (int k = 0; k < n; k++) begin
            do sq_bit = 64'd1 << $urandom_range(63); while ((occ & sq_bit) != 0);
            occ |= sq_bit;
            if (with_kings && k < 2) begin
                kind     = bbpr_pkg::PC_KING;
                is_black = (k == 1);
            end else begin
                kind     = ($urandom_range(49) == 0) ? bbpr_pkg::PC_KING
                                                     : 3'($urandom_range(4));
                is_black = 1'($urandom_range(1));
            end
            if (is_black) p.black_pieces |= sq_bit;
            else          p.white_pieces |= sq_bit;
            case (kind)
                bbpr_pkg::PC_PAWN:   p.pawn_board   |= sq_bit;
                bbpr_pkg::PC_KNIGHT: p.knight_board |= sq_bit;
                bbpr_pkg::PC_BISHOP: p.bishop_board |= sq_bit;
                bbpr_pkg::PC_ROOK:   p.rook_board   |= sq_bit;
                bbpr_pkg::PC_QUEEN:  p.queen_board  |= sq_bit;
                default:             p.king_board   |= sq_bit;
            endcase
        end
        p.black_to_move    = 1'($urandom_range(1));
        p.score_white_view = random_score();
        p.game_outcome     = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_special_cases();
        logic [63:0] ones;
        ones = '1;
        // empty board, kings absent
        send_position(position(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'd0, 2'd1));
        // opening position from both sides; score saturation, outcome 3
        send_position(position(64'h0000_0000_0000_FFFF, 64'hFFFF_0000_0000_0000,
            64'h00FF_0000_0000_FF00, 64'h4200_0000_0000_0042, 64'h2400_0000_0000_0024,
            64'h8100_0000_0000_0081, 64'h0800_0000_0000_0008, 64'h1000_0000_0000_0010,
            1'b0, 16'd0, 2'd2));
        send_position(position(64'h0000_0000_0000_FFFF, 64'hFFFF_0000_0000_0000,
            64'h00FF_0000_0000_FF00, 64'h4200_0000_0000_0042, 64'h2400_0000_0000_0024,
            64'h8100_0000_0000_0081, 64'h0800_0000_0000_0008, 64'h1000_0000_0000_0010,
            1'b1, 16'h8000, 2'd3));
        send_position(position(64'h0000_0000_0000_FFFF, 64'hFFFF_0000_0000_0000,
            64'h00FF_0000_0000_FF00, 64'h4200_0000_0000_0042, 64'h2400_0000_0000_0024,
            64'h8100_0000_0000_0081, 64'h0800_0000_0000_0008, 64'h1000_0000_0000_0010,
            1'b1, 16'h7FFF, 2'd0));
        // everything set: overflow past the piece limit, both colors, many kings
        send_position(position(ones, ones, ones, ones, ones, ones, ones, ones,
            1'b1, -16'sd30000, 2'd1));
        send_position(position(ones, ones, ones, ones, ones, ones, ones, ones,
            1'b0, 16'sd30000, 2'd2));
        // occupied squares without any piece type
        send_position(position(ones, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'd1, 2'd0));
        send_position(position(0, ones, 0, 0, 0, 0, 0, 0, 1'b1, 16'hFFFF, 2'd1));
        // one square claimed by both colors
        send_position(position(64'h1, 64'h1, 0, 0, 0, 0, 0, 64'h1, 1'b0, 16'd5, 2'd2));
        send_position(position(64'h1, 64'h1, 0, 0, 0, 0, 0, 64'h1, 1'b1, 16'd5, 2'd2));
        // exactly at the limit, then one over
        send_position(position(64'h0000_0000_FFFF_FFFF, 0, 64'h0000_0000_FFFF_FFFF,
            0, 0, 0, 0, 0, 1'b0, 16'd100, 2'd1));
        send_position(position(64'h0000_0001_FFFF_FFFF, 0, 0, 0, 0, ones, 0, 0,
            1'b1, 16'd100, 2'd1));
        // several kings per side, lowest one counts
        send_position(position(64'h8000_0000_0000_0081, 64'h0100_0000_8000_0000,
            0, 0, 0, 0, 0, 64'h8100_0000_8000_0081, 1'b0, -16'sd1, 2'd0));
        send_position(position(64'h8000_0000_0000_0081, 64'h0100_0000_8000_0000,
            0, 0, 0, 0, 0, 64'h8100_0000_8000_0081, 1'b1, -16'sd1, 2'd0));
        // each piece type per color
        send_position(position(64'h3F, 64'hFC00_0000_0000_0000,
            64'h0400_0000_0000_0001, 64'h0800_0000_0000_0002, 64'h1000_0000_0000_0004,
            64'h2000_0000_0000_0008, 64'h4000_0000_0000_0010, 64'h8000_0000_0000_0020,
            1'b1, 16'd250, 2'd2));
        // overlapping piece boards: first type wins
        send_position(position(64'hF, 0, 64'hA, 64'hF, 64'hF, 0, 0, 64'hF,
            1'b0, 16'd0, 2'd1));
        // top square only
        send_position(position(0, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0,
            64'h8000_0000_0000_0000, 1'b0, 16'd7, 2'd3));
        send_position(position(0, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0,
            64'h8000_0000_0000_0000, 1'b1, 16'd7, 2'd3));
    endtask

    task automatic test_legal_positions(input int count);
        int n;
        for (int i = 0; i < count; i++) begin
            n = ($urandom_range(3) == 0) ? $urandom_range(32, 24) : $urandom_range(12, 2);
            send_position(legal_position(n));
        end
    endtask

    // raw boards: overlaps, missing pieces, over-full positions, any score
    task automatic test_raw_bitboards(input int count);
        bbpr_pkg::t_in_item p;
        logic [63:0] mask;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(2))
                0:       mask = '1;
                1:       mask = rand64() & rand64();
                default: mask = rand64() & rand64() & rand64();
            endcase
            p = position(rand64() & mask, rand64() & mask, rand64(), rand64(),
                rand64(), rand64(), rand64(), rand64() & rand64(),
                1'($urandom_range(1)), 16'($urandom), 2'($urandom_range(3)));
            send_position(p);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        i_out_stall     = 1'b0;
        mismatch_count  = 0;
        records_checked = 0;
        cycle_count     = 0;
        set_idling(0, 0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        wait_all_returned();

        set_idling(0, 0);
        test_legal_positions(180);
        test_raw_bitboards(50);
        set_idling(58, 0);
        test_legal_positions(180);
        test_raw_bitboards(50);
        wait_all_returned();
        set_idling(0, 58);
        test_legal_positions(180);
        test_raw_bitboards(50);
        set_idling(6, 6);
        test_legal_positions(180);
        test_raw_bitboards(50);

        wait_all_returned();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
